// File: rtl/src_pkg.sv
// Shared types, constants and table functions of the stereo RMS compressor.
package src_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int CHUNK_LEN_DEF   = 8;
    localparam int DIV_DW          = 48;
    localparam int DIV_VW          = 40;
    localparam int MUL_W           = 33;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_LAST   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_RATIO     = 3'd1;
    localparam logic [2:0] REG_ATTACK    = 3'd2;
    localparam logic [2:0] REG_RELEASE   = 3'd3;
    localparam logic [2:0] REG_MAKEUP    = 3'd4;
    localparam logic [2:0] REG_RATE      = 3'd5;

    typedef enum logic [5:0] {
        S_IDLE, S_DIV_WAIT, S_EXP, S_P2_INIT, S_P2_MUL, S_P2_ACC, S_P2_FIN,
        S_A_DIV, S_SQ_L, S_TRK_L, S_UPD_L, S_SQ_R, S_TRK_R, S_UPD_R,
        S_C_THR, S_C_MK, S_C_ATK, S_C_REL, S_C_LVL, S_C_NORM, S_C_LSQ, S_C_LSQ2,
        S_C_LMUL, S_C_LVL2, S_C_TGT, S_C_TGT2, S_C_DEN, S_C_CDIV, S_C_STEP,
        S_C_STEP2, S_C_LIN, S_C_LIN2, S_C_G,
        S_E_RD, S_E_ML, S_E_MR, S_E_OUTC, S_E_OUT
    } t_state;

    typedef struct packed {
        logic                start;
        logic [DIV_DW-1:0]   dividend;
        logic [DIV_VW-1:0]   divisor;
    } t_div_req;

    typedef logic [15:0][31:0] t_ctab;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        logic [63:0] x;
        res = '0;
        b   = 64'h4000_0000_0000_0000;
        x   = v;
        for (int j = 0; j < 32; j++) begin
            if (b > x) b = b >> 2;
        end
        for (int j = 0; j < 32; j++) begin
            if (b != 0) begin
                if (x >= res + b) begin
                    x   = x - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
        end
        return res;
    endfunction

    // Root chain 2^(32 - 2^-(i+1)) for the fractional power of two.
    function automatic t_ctab f_ctab();
        t_ctab       t;
        logic [63:0] c;
        c = isqrt64(64'h8000_0000_0000_0000);
        for (int i = 0; i < 16; i++) begin
            t[i] = c[31:0];
            c = isqrt64({c[31:0], 32'h0});
        end
        return t;
    endfunction

    localparam t_ctab CTAB = f_ctab();

endpackage

// File: rtl/src_div.sv
// Restoring divider, one quotient bit per cycle.
module src_div
    import src_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    output logic              o_done,
    output logic [DIV_DW-1:0] o_quotient
);
    localparam int CW = $clog2(DIV_DW + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [DIV_VW-1:0] r_rem, n_rem;
    logic [DIV_VW-1:0] r_den, n_den;
    logic [DIV_DW-1:0] r_quo, n_quo;
    logic [DIV_VW:0]   trial;

    assign trial = {r_rem, r_quo[DIV_DW-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DIV_DW);
            n_rem  = '0;
            n_den  = i_req.divisor;
            n_quo  = i_req.dividend;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = DIV_VW'(trial - {1'b0, r_den});
                n_quo = {r_quo[DIV_DW-2:0], 1'b1};
            end else begin
                n_rem = trial[DIV_VW-1:0];
                n_quo = {r_quo[DIV_DW-2:0], 1'b0};
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: rtl/stereo_rms_compressor_unit.sv
// Top level of the stereo RMS compressor: sequencer, shared multiplier, chunk buffer.
//
// Input channel (i_in_valid / o_in_stall): one transfer carries an opcode and a
// stereo sample pair. A sample updates both mean-square estimators and is buffered;
// a clear zeroes the estimators and the gain and empties the buffer.
// Output channel (o_out_valid / i_out_stall): when a chunk closes (CHUNK_LEN pairs,
// or an end-of-block sample), the buffered pairs leave in order, scaled by the
// smoothed gain, o_chunk_last set on the final one.
// Configuration: i_cfg_wr_en writes register i_cfg_index with i_cfg_data; write
// only while the block is idle.
// Sequence: after a sample is taken, the block waits on the divider for the filter
// coefficient, runs the power-of-two loop on the shared 33x33 multiplier, then the
// two tracking updates, before it takes the next sample. A closing chunk adds
// register scaling by reciprocal multiply, the log search and squaring loop, the
// target divide when above threshold, the coefficient divide and two more
// power-of-two loops, then the emission of each pair. o_in_stall is high throughout.
// Reset clears the registers to their defaults and empties estimators and buffer.
// A stalled output pair holds, and no input is taken until the chunk drains.
module stereo_rms_compressor_unit
    import src_pkg::*;
#(
    parameter int CHUNK_LEN = CHUNK_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_opcode,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_left,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_right,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_out_left,
    output logic signed [SAMPLE_BITS-1:0] o_out_right,
    output logic                          o_chunk_last,
    input  logic                          i_cfg_wr_en,
    input  logic [2:0]                    i_cfg_index,
    input  logic [17:0]                   i_cfg_data
);
    localparam int SB    = SAMPLE_BITS;
    localparam int FW    = $clog2(CHUNK_LEN + 1);
    localparam int AW    = (CHUNK_LEN > 1) ? $clog2(CHUNK_LEN) : 1;
    localparam int SQ_SH = 2 * SB - 34;
    localparam logic [DIV_DW-1:0] NUM = DIV_DW'(64'(CHUNK_LEN) * 64'd65536000000);
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
    // ceil(2^38 / 255): exact floor(n / 255) as (n * RECIP_255) >> 38 for n < 2^30
    localparam logic [32:0] RECIP_255 = 33'd1077952577;

    // saturate a scaled magnitude back to a signed sample
    function automatic logic [SB-1:0] f_sat(input logic [41:0] v, input logic neg);
        logic [41:0] lim;
        logic [41:0] lm1;
        logic [41:0] nv;
        lim = 42'(1) << (SB - 1);
        lm1 = lim - 42'(1);
        nv  = -v;
        if (neg) begin
            if (v > lim) return lim[SB-1:0];
            return nv[SB-1:0];
        end
        if (v > lm1) return lm1[SB-1:0];
        return v[SB-1:0];
    endfunction

    // configuration registers
    logic [7:0]  r_thr_code, r_ratio_code, r_atk_code, r_rel_code, r_mk_code;
    logic [17:0] r_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_code   <= 8'd192;
            r_ratio_code <= 8'd64;
            r_atk_code   <= 8'd32;
            r_rel_code   <= 8'd96;
            r_mk_code    <= 8'd128;
            r_rate       <= 18'd48000;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_THRESHOLD: r_thr_code   <= i_cfg_data[7:0];
                REG_RATIO:     r_ratio_code <= i_cfg_data[7:0];
                REG_ATTACK:    r_atk_code   <= i_cfg_data[7:0];
                REG_RELEASE:   r_rel_code   <= i_cfg_data[7:0];
                REG_MAKEUP:    r_mk_code    <= i_cfg_data[7:0];
                REG_RATE:      r_rate       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [17:0] sr_eff;
    assign sr_eff = (r_rate < 18'd8000) ? 18'd8000 :
                    (r_rate > 18'd192000) ? 18'd192000 : r_rate;

    // sequencer state
    t_state r_state, n_state, r_ret_d, n_ret_d, r_ret_p, n_ret_p;
    logic [31:0]        r_pl, n_pl, r_pr, n_pr;
    logic signed [23:0] r_gain, n_gain;
    logic [FW-1:0]      r_fill, n_fill;
    logic [AW-1:0]      r_idx, n_idx;
    logic               r_close, n_close;
    logic [SB-1:0]      r_sl, n_sl, r_sr, n_sr;
    logic [32:0]        r_alpha, n_alpha;
    logic [32:0]        r_acc, n_acc;
    logic [39:0]        r_u, n_u;
    logic [3:0]         r_i, n_i;
    logic               r_up, n_up;
    logic signed [25:0] r_thr, n_thr, r_lvl, n_lvl, r_tgt, n_tgt, r_d, n_d;
    logic [25:0]        r_mk, n_mk;
    logic [16:0]        r_atk, n_atk;
    logic [20:0]        r_rel, n_rel;
    logic [32:0]        r_m, n_m;
    logic [4:0]         r_k, n_k;
    logic [15:0]        r_frac, n_frac;
    logic               r_neg, n_neg;
    logic signed [7:0]  r_c, n_c;
    logic [32:0]        r_g, n_g;
    logic [SB-1:0]      r_ol, n_ol, r_or, n_or;
    logic               r_ovalid, n_ovalid, r_olast, n_olast;

    // shared multiplier, product registered
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [65:0]        r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 66'(mul_a) * 66'(mul_b);
    end

    // divider
    t_div_req          div_req;
    logic              div_done;
    logic [DIV_DW-1:0] div_q;

    src_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // chunk buffer
    logic [2*SB-1:0] r_buf [CHUNK_LEN];
    logic [2*SB-1:0] r_rd;
    logic            in_acc, in_smp;

    assign in_acc = i_in_valid && !o_in_stall;
    assign in_smp = in_acc && (i_opcode == OP_SAMPLE || i_opcode == OP_LAST);

    always_ff @(posedge i_clk) begin
        if (in_smp) r_buf[r_fill[AW-1:0]] <= {i_sample_left, i_sample_right};
        r_rd <= r_buf[r_idx];
    end

    // datapath helpers
    logic signed [SB:0] ext_l, ext_r, ext_bl, ext_br;
    logic [SB:0]        abs_l, abs_r, abs_bl, abs_br;
    logic [65:0]        sq_full;
    logic [31:0]        x2, trk_diff;
    logic [32:0]        p_sum;
    logic [33:0]        mm;
    logic [21:0]        mag;
    logic signed [25:0] gain_ext, diff, t_val, y_val;
    logic [25:0]        abs_diff, abs_t, ym;
    logic [26:0]        y_round;
    logic [47:0]        g_shift;
    logic [7:0]         neg_c;
    logic [25:0]        q255;

    assign ext_l  = {r_sl[SB-1], r_sl};
    assign ext_r  = {r_sr[SB-1], r_sr};
    assign ext_bl = {r_rd[2*SB-1], r_rd[2*SB-1:SB]};
    assign ext_br = {r_rd[SB-1], r_rd[SB-1:0]};
    assign abs_l  = ext_l[SB]  ? (SB+1)'(-ext_l)  : (SB+1)'(ext_l);
    assign abs_r  = ext_r[SB]  ? (SB+1)'(-ext_r)  : (SB+1)'(ext_r);
    assign abs_bl = ext_bl[SB] ? (SB+1)'(-ext_bl) : (SB+1)'(ext_bl);
    assign abs_br = ext_br[SB] ? (SB+1)'(-ext_br) : (SB+1)'(ext_br);

    always_comb begin
        if (SQ_SH >= 0) sq_full = r_prod >> SQ_SH;
        else            sq_full = r_prod << (-SQ_SH);
    end
    assign x2       = (|sq_full[65:32]) ? 32'hFFFF_FFFF : sq_full[31:0];
    assign trk_diff = (r_state == S_TRK_L) ?
                      ((x2 >= r_pl) ? x2 - r_pl : r_pl - x2) :
                      ((x2 >= r_pr) ? x2 - r_pr : r_pr - x2);

    assign p_sum    = 33'(r_pl) + 33'(r_pr);
    assign mm       = r_prod[64:31];
    assign mag      = ({16'h0, 6'(6'd32 - 6'(r_k))} << 16) - 22'(r_frac);
    assign q255     = r_prod[63:38];

    assign gain_ext = 26'(r_gain);
    assign diff     = r_tgt - gain_ext;
    assign abs_diff = diff[25] ? 26'(-diff) : 26'(diff);
    assign t_val    = gain_ext + $signed(r_mk);
    assign abs_t    = t_val[25] ? 26'(-t_val) : 26'(t_val);
    assign ym       = r_prod[41:16];
    assign y_val    = r_neg ? -$signed(ym) : $signed(ym);
    assign y_round  = 27'(ym) + 27'd65535;
    assign neg_c    = 8'(-r_c);
    assign g_shift  = r_c[7] ? (48'(r_acc) >> neg_c[6:0]) : (48'(r_acc) << r_c[5:0]);

    // next state and datapath control
    always_comb begin
        n_state = r_state;  n_ret_d = r_ret_d;  n_ret_p = r_ret_p;
        n_pl = r_pl;  n_pr = r_pr;  n_gain = r_gain;  n_fill = r_fill;
        n_idx = r_idx;  n_close = r_close;  n_sl = r_sl;  n_sr = r_sr;
        n_alpha = r_alpha;  n_acc = r_acc;  n_u = r_u;  n_i = r_i;  n_up = r_up;
        n_thr = r_thr;  n_lvl = r_lvl;  n_tgt = r_tgt;  n_d = r_d;  n_mk = r_mk;
        n_atk = r_atk;  n_rel = r_rel;  n_m = r_m;  n_k = r_k;  n_frac = r_frac;
        n_neg = r_neg;  n_c = r_c;  n_g = r_g;  n_ol = r_ol;  n_or = r_or;
        n_ovalid = r_ovalid;  n_olast = r_olast;
        mul_a = '0;
        mul_b = '0;
        div_req = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_opcode == OP_CLEAR) begin
                    n_pl = '0;  n_pr = '0;  n_gain = '0;  n_fill = '0;
                end else if (in_smp) begin
                    n_sl    = i_sample_left;
                    n_sr    = i_sample_right;
                    n_fill  = r_fill + FW'(1);
                    n_close = (r_fill + FW'(1) >= FW'(CHUNK_LEN)) || (i_opcode == OP_LAST);
                    n_state = S_A_DIV;
                end
            end
            S_DIV_WAIT: if (div_done) n_state = r_ret_d;
            S_EXP: begin
                mul_a   = div_q[MUL_W-1:0];
                mul_b   = MUL_W'(94548);
                n_state = S_P2_INIT;
            end
            S_P2_INIT: begin
                n_u = r_prod[55:16];  n_acc = ONE_Q32;  n_i = '0;
                n_state = S_P2_MUL;
            end
            S_P2_MUL: begin
                mul_a   = r_acc;
                mul_b   = {1'b0, CTAB[r_i]};
                n_state = S_P2_ACC;
            end
            S_P2_ACC: begin
                if (r_u[4'd15 - r_i]) n_acc = r_prod[64:32];
                n_i     = r_i + 4'd1;
                n_state = (r_i == 4'd15) ? S_P2_FIN : S_P2_MUL;
            end
            S_P2_FIN: begin
                n_acc   = (r_u[39:16] >= 24'd33) ? '0 : (r_acc >> r_u[21:16]);
                n_state = r_ret_p;
            end
            // sample path: filter coefficient, then both channels
            S_A_DIV: begin
                div_req = '{start: 1'b1, dividend: DIV_DW'(6553600), divisor: DIV_VW'(sr_eff)};
                n_ret_d = S_EXP;  n_ret_p = S_SQ_L;  n_state = S_DIV_WAIT;
            end
            S_SQ_L: begin
                n_alpha = ONE_Q32 - r_acc;
                mul_a = MUL_W'(abs_l);  mul_b = MUL_W'(abs_l);
                n_state = S_TRK_L;
            end
            S_TRK_L: begin
                n_up  = x2 >= r_pl;
                mul_a = r_alpha;  mul_b = MUL_W'(trk_diff);
                n_state = S_UPD_L;
            end
            S_UPD_L: begin
                n_pl  = r_up ? r_pl + r_prod[63:32] : r_pl - r_prod[63:32];
                mul_a = MUL_W'(abs_r);  mul_b = MUL_W'(abs_r);
                n_state = S_TRK_R;
            end
            S_SQ_R: n_state = S_TRK_R;
            S_TRK_R: begin
                n_up  = x2 >= r_pr;
                mul_a = r_alpha;  mul_b = MUL_W'(trk_diff);
                n_state = S_UPD_R;
            end
            S_UPD_R: begin
                n_pr    = r_up ? r_pr + r_prod[63:32] : r_pr - r_prod[63:32];
                n_state = r_close ? S_C_THR : S_IDLE;
            end
            // chunk close: scaled register values, divide by 255 as reciprocal multiply
            S_C_THR: begin
                mul_a   = MUL_W'(33'(r_thr_code) * 33'd3932160);
                mul_b   = RECIP_255;
                n_state = S_C_MK;
            end
            S_C_MK: begin
                n_thr   = $signed(q255) - 26'sd3932160;
                mul_a   = MUL_W'(33'(r_mk_code) * 33'd1572864);
                mul_b   = RECIP_255;
                n_state = S_C_ATK;
            end
            S_C_ATK: begin
                n_mk    = q255;
                mul_a   = MUL_W'(33'(r_atk_code) * 33'd99900);
                mul_b   = RECIP_255;
                n_state = S_C_REL;
            end
            S_C_REL: begin
                n_atk   = 17'(q255) + 17'd100;
                mul_a   = MUL_W'(33'(r_rel_code) * 33'd1990000);
                mul_b   = RECIP_255;
                n_state = S_C_LVL;
            end
            // level in dB: normalize, square for the fraction bits, scale
            S_C_LVL: begin
                n_rel = 21'(q255) + 21'd10000;
                if (p_sum[32:1] == 32'h0) begin
                    n_lvl   = -26'sd11796480;
                    n_state = S_C_TGT;
                end else begin
                    n_m = {1'b0, p_sum[32:1]};  n_k = 5'd31;
                    n_state = S_C_NORM;
                end
            end
            S_C_NORM: begin
                if (r_m[31]) begin
                    n_frac = '0;  n_i = '0;  n_state = S_C_LSQ;
                end else begin
                    n_m = {r_m[31:0], 1'b0};  n_k = r_k - 5'd1;
                end
            end
            S_C_LSQ: begin
                mul_a = r_m;  mul_b = r_m;
                n_state = S_C_LSQ2;
            end
            S_C_LSQ2: begin
                if (mm[32]) begin
                    n_frac = {r_frac[14:0], 1'b1};  n_m = mm[33:1];
                end else begin
                    n_frac = {r_frac[14:0], 1'b0};  n_m = mm[32:0];
                end
                n_i     = r_i + 4'd1;
                n_state = (r_i == 4'd15) ? S_C_LMUL : S_C_LSQ;
            end
            S_C_LMUL: begin
                mul_a = MUL_W'(mag);  mul_b = MUL_W'(197284);
                n_state = S_C_LVL2;
            end
            S_C_LVL2: begin
                n_lvl   = -$signed({2'b00, r_prod[39:16]});
                n_state = S_C_TGT;
            end
            // target gain from threshold and ratio
            S_C_TGT: begin
                if (r_lvl > r_thr) begin
                    n_d     = r_lvl - r_thr;
                    div_req = '{start: 1'b1,
                                dividend: 48'(26'(r_lvl - r_thr)) * 48'd255,
                                divisor: 40'd255 + 40'(r_ratio_code) * 40'd19};
                    n_ret_d = S_C_TGT2;  n_state = S_DIV_WAIT;
                end else begin
                    n_tgt   = '0;
                    n_state = S_C_DEN;
                end
            end
            S_C_TGT2: begin
                n_tgt   = $signed(26'(div_q)) - r_d;
                n_state = S_C_DEN;
            end
            // smoothing coefficient: attack when the gain falls, else release
            S_C_DEN: begin
                mul_a   = MUL_W'(sr_eff);
                mul_b   = (r_tgt < gain_ext) ? MUL_W'(r_atk) : MUL_W'(r_rel);
                n_state = S_C_CDIV;
            end
            S_C_CDIV: begin
                div_req = '{start: 1'b1, dividend: NUM, divisor: r_prod[DIV_VW-1:0]};
                n_ret_d = S_EXP;  n_ret_p = S_C_STEP;  n_state = S_DIV_WAIT;
            end
            S_C_STEP: begin
                n_neg = diff[25];
                mul_a = ONE_Q32 - r_acc;  mul_b = MUL_W'(abs_diff);
                n_state = S_C_STEP2;
            end
            S_C_STEP2: begin
                n_gain  = r_neg ? 24'(gain_ext - $signed({1'b0, r_prod[56:32]}))
                                : 24'(gain_ext + $signed({1'b0, r_prod[56:32]}));
                n_state = S_C_LIN;
            end
            // linear gain: log2 scale, split integer and fraction, power of two
            S_C_LIN: begin
                n_neg = t_val[25];
                mul_a = MUL_W'(abs_t);  mul_b = MUL_W'(10885);
                n_state = S_C_LIN2;
            end
            S_C_LIN2: begin
                n_c     = r_neg ? -$signed(8'(ym >> 16)) : $signed(8'(y_round >> 16));
                n_u     = {24'h0, 16'(-y_val)};
                n_acc   = ONE_Q32;  n_i = '0;
                n_ret_p = S_C_G;  n_state = S_P2_MUL;
            end
            S_C_G: begin
                n_g     = g_shift[40:8];
                n_idx   = '0;
                n_state = S_E_RD;
            end
            // emit the buffered pairs
            S_E_RD: n_state = S_E_ML;
            S_E_ML: begin
                mul_a = MUL_W'(abs_bl);  mul_b = r_g;
                n_state = S_E_MR;
            end
            S_E_MR: begin
                n_ol  = f_sat(r_prod[65:24], ext_bl[SB]);
                mul_a = MUL_W'(abs_br);  mul_b = r_g;
                n_state = S_E_OUTC;
            end
            S_E_OUTC: begin
                n_or     = f_sat(r_prod[65:24], ext_br[SB]);
                n_ovalid = 1'b1;
                n_olast  = (FW'(r_idx) + FW'(1) == r_fill);
                n_state  = S_E_OUT;
            end
            S_E_OUT: begin
                if (!i_out_stall) begin
                    n_ovalid = 1'b0;
                    if (r_olast) begin
                        n_fill  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_E_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret_d  <= S_IDLE;
            r_ret_p  <= S_IDLE;
            r_pl     <= '0;
            r_pr     <= '0;
            r_gain   <= '0;
            r_fill   <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret_d  <= n_ret_d;
            r_ret_p  <= n_ret_p;
            r_pl     <= n_pl;
            r_pr     <= n_pr;
            r_gain   <= n_gain;
            r_fill   <= n_fill;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_close <= n_close;  r_sl <= n_sl;  r_sr <= n_sr;  r_alpha <= n_alpha;
        r_acc <= n_acc;  r_u <= n_u;  r_i <= n_i;  r_up <= n_up;  r_thr <= n_thr;
        r_lvl <= n_lvl;  r_tgt <= n_tgt;  r_d <= n_d;  r_mk <= n_mk;  r_atk <= n_atk;
        r_rel <= n_rel;  r_m <= n_m;  r_k <= n_k;  r_frac <= n_frac;  r_neg <= n_neg;
        r_c <= n_c;  r_g <= n_g;  r_ol <= n_ol;  r_or <= n_or;  r_olast <= n_olast;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_ovalid;
    assign o_out_left   = r_ol;
    assign o_out_right  = r_or;
    assign o_chunk_last = r_olast;

    // the buffer never holds more than one chunk
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(CHUNK_LEN))
        else $error("chunk fill beyond chunk length");

    // a result only comes out of a non-empty chunk
    a_out_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_fill != '0 && r_state == S_E_OUT))
        else $error("result without buffered data");

    // the last transfer of a chunk empties the buffer and frees the input side
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_chunk_last) |=> (r_fill == '0 && !o_in_stall))
        else $error("chunk not drained after last transfer");

endmodule
